>>> sv/biou_pkg.sv
// ----------------------------------------------------------------------------
// biou_pkg
// Shared constants and types for the box IoU pipeline.
// ----------------------------------------------------------------------------
package biou_pkg;

    localparam int FIELD_W    = 16;
    localparam int NUM_FIELDS = 8;
    localparam int S_TDATA_W  = FIELD_W * NUM_FIELDS;
    localparam int RATIO_W    = 17;
    localparam int M_TDATA_W  = 24;
    localparam int QUO_BITS   = 17;

    localparam logic [RATIO_W-1:0] THR_RESET = 17'd32768;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

endpackage

>>> sv/biou_geom.sv
// ----------------------------------------------------------------------------
// biou_geom
// Corner, overlap, area and union stages of the box IoU pipeline.
// ----------------------------------------------------------------------------
module biou_geom #(
    parameter int CW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [biou_pkg::S_TDATA_W-1:0] i_data,
    output biou_pkg::t_ctl                o_ctl,
    output logic [2*CW+1:0]               o_inter,
    output logic [2*CW+2:0]               o_uni
);
    import biou_pkg::*;

    logic [CW-1:0]        c1 [2];
    logic [CW-1:0]        s1 [2];
    logic [CW-1:0]        c2 [2];
    logic [CW-1:0]        s2 [2];
    logic signed [CW+2:0] lo1 [2];
    logic signed [CW+2:0] hi1 [2];
    logic signed [CW+2:0] lo2 [2];
    logic signed [CW+2:0] hi2 [2];
    logic signed [CW+2:0] n1_lo [2];
    logic signed [CW+2:0] n1_hi [2];
    logic signed [CW+2:0] dif [2];
    logic [CW:0]          n2_ov [2];

    logic                 r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [CW+2:0] r1_lo [2];
    logic signed [CW+2:0] r1_hi [2];
    logic [CW-1:0]        r1_ah, r1_aw, r1_th, r1_tw;
    logic [CW:0]          r2_ov [2];
    logic [2*CW-1:0]      r2_area_a, r2_area_t;
    logic [2*CW+1:0]      r3_inter;
    logic [2*CW+2:0]      r3_sum;
    logic [2*CW+1:0]      r4_inter;
    logic [2*CW+2:0]      r4_uni;
    logic                 r4_zero;

    assign c1[0] = i_data[0*FIELD_W +: CW];
    assign c1[1] = i_data[1*FIELD_W +: CW];
    assign s1[0] = i_data[2*FIELD_W +: CW];
    assign s1[1] = i_data[3*FIELD_W +: CW];
    assign c2[0] = i_data[4*FIELD_W +: CW];
    assign c2[1] = i_data[5*FIELD_W +: CW];
    assign s2[0] = i_data[6*FIELD_W +: CW];
    assign s2[1] = i_data[7*FIELD_W +: CW];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            lo1[a]   = $signed({2'b00, c1[a], 1'b0}) - $signed({3'b000, s1[a]});
            hi1[a]   = $signed({2'b00, c1[a], 1'b0}) + $signed({3'b000, s1[a]});
            lo2[a]   = $signed({2'b00, c2[a], 1'b0}) - $signed({3'b000, s2[a]});
            hi2[a]   = $signed({2'b00, c2[a], 1'b0}) + $signed({3'b000, s2[a]});
            n1_lo[a] = (lo1[a] > lo2[a]) ? lo1[a] : lo2[a];
            n1_hi[a] = (hi1[a] < hi2[a]) ? hi1[a] : hi2[a];
            dif[a]   = r1_hi[a] - r1_lo[a];
            n2_ov[a] = (dif[a] > 0) ? dif[a][CW:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld  <= i_vld;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lo     <= n1_lo;
            r1_hi     <= n1_hi;
            r1_ah     <= s1[0];
            r1_aw     <= s1[1];
            r1_th     <= s2[0];
            r1_tw     <= s2[1];
            r2_ov     <= n2_ov;
            r2_area_a <= r1_ah * r1_aw;
            r2_area_t <= r1_th * r1_tw;
            r3_inter  <= r2_ov[0] * r2_ov[1];
            r3_sum    <= {1'b0, r2_area_a, 2'b00} + {1'b0, r2_area_t, 2'b00};
            r4_inter  <= r3_inter;
            r4_uni    <= r3_sum - {1'b0, r3_inter};
            r4_zero   <= (r3_sum == {1'b0, r3_inter});
        end
    end

    assign o_ctl   = '{vld: r4_vld, zero: r4_zero};
    assign o_inter = r4_inter;
    assign o_uni   = r4_uni;

endmodule

>>> sv/biou_div.sv
// ----------------------------------------------------------------------------
// biou_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module biou_div #(
    parameter int CW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  biou_pkg::t_ctl                i_ctl,
    input  logic [2*CW+1:0]               i_inter,
    input  logic [2*CW+2:0]               i_uni,
    output biou_pkg::t_ctl                o_ctl,
    output logic [biou_pkg::QUO_BITS-1:0] o_quo
);
    import biou_pkg::*;

    localparam int UW = 2 * CW + 3;
    localparam int RW = UW + 1;

    t_ctl                r_ctl [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS];
    logic [UW-1:0]       r_rem [QUO_BITS-1];
    logic [UW-1:0]       r_uni [QUO_BITS-1];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic [RW-1:0]       rin;
        logic [UW-1:0]       uin;
        logic [QUO_BITS-1:0] qin;
        t_ctl                cin;
        logic                ge;

        if (k == 0) begin : g_first
            assign rin = RW'(i_inter);
            assign uin = i_uni;
            assign qin = '0;
            assign cin = i_ctl;
        end else begin : g_next
            assign rin = {r_rem[k-1], 1'b0};
            assign uin = r_uni[k-1];
            assign qin = r_quo[k-1];
            assign cin = r_ctl[k-1];
        end

        assign ge = (rin >= {1'b0, uin});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k] <= cin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {qin[QUO_BITS-2:0], ge};
            end
        end

        if (k < QUO_BITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? UW'(rin - {1'b0, uin}) : UW'(rin);
                    r_uni[k] <= uin;
                end
            end
        end
    end

    assign o_ctl = r_ctl[QUO_BITS-1];
    assign o_quo = r_quo[QUO_BITS-1];

endmodule

>>> sv/box_iou_center_size.sv
// ----------------------------------------------------------------------------
// box_iou_center_size
// IoU of an anchor box and a ground-truth box given as center and size,
// with a match flag against a programmable threshold.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s (in)    in   128    tdata: anchor_cy, anchor_cx, anchor_height,
//                        anchor_width, truth_cy, truth_cx, truth_height,
//                        truth_width (16 bits each, lowest first)
//  m (out)   out  24/1   tdata: overlap_ratio[16:0]; tuser: above_threshold
//  cfg       in   17     match_threshold, written when i_cfg_we is high
//
// One item per cycle unless the output stalls; the pipeline has four geometry
// stages, seventeen divider stages (one quotient bit each) and one output stage.
// Reset clears all valid bits and sets the threshold to 0.5.
// A stalled output parks one item in a skid register; the pipeline then
// holds and o_s_tready drops until the skid register drains.
// ----------------------------------------------------------------------------
module box_iou_center_size #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [biou_pkg::S_TDATA_W-1:0] i_s_tdata,   // anchor_cy .. truth_width
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [biou_pkg::M_TDATA_W-1:0] o_m_tdata,   // overlap_ratio
    output logic                           o_m_tuser,   // above_threshold
    input  logic                           i_cfg_we,
    input  logic [biou_pkg::RATIO_W-1:0]   i_cfg_wdata
);
    import biou_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    logic                en;
    t_ctl                geom_ctl;
    logic [2*CW+1:0]     geom_inter;
    logic [2*CW+2:0]     geom_uni;
    t_ctl                div_ctl;
    logic [QUO_BITS-1:0] div_quo;
    logic [RATIO_W-1:0]  n_ratio;

    logic [RATIO_W-1:0]  r_thr;
    logic                r_out_vld;
    logic [RATIO_W-1:0]  r_ratio;
    logic                r_flag;
    logic                r_sk_vld;
    logic [RATIO_W-1:0]  r_sk_ratio;
    logic                r_sk_flag;

    assign en         = !r_sk_vld;
    assign o_s_tready = en;

    biou_geom #(.CW(CW)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ctl   (geom_ctl),
        .o_inter (geom_inter),
        .o_uni   (geom_uni)
    );

    biou_div #(.CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geom_ctl),
        .i_inter (geom_inter),
        .i_uni   (geom_uni),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo)
    );

    assign n_ratio = div_ctl.zero ? '0 : RATIO_W'(div_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ratio <= n_ratio;
            r_flag  <= (n_ratio > r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (i_m_tready) begin
                r_sk_vld <= 1'b0;
            end
        end else if (r_out_vld && !i_m_tready) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_ratio <= r_ratio;
            r_sk_flag  <= r_flag;
        end
    end

    assign o_m_tvalid = r_sk_vld | r_out_vld;
    assign o_m_tdata  = M_TDATA_W'(r_sk_vld ? r_sk_ratio : r_ratio);
    assign o_m_tuser  = r_sk_vld ? r_sk_flag : r_flag;

endmodule
